/* rtl/arb_pkg.sv */
// ----------------------------------------------------------------------------
// arb_pkg
// Shared types, register codes and a fixed-point helper of the affine
// rectangle bounds unit.
// ----------------------------------------------------------------------------
package arb_pkg;

	localparam int COORD_W = 32;   // Q16.16 coordinate
	localparam int EXT_W   = 33;   // far corner, one bit of headroom
	localparam int SIZE_W  = 31;   // rect width and height
	localparam int COEF_W  = 24;   // Q8.16 coefficient
	localparam int PROD_W  = COEF_W + EXT_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int QUO_W   = SUM_W - 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam int N_CORNER  = 4;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_A   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_C   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_D   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;

	localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sh010000;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

	// Corner i takes the far x (resp. y) edge when bit i is set.
	localparam logic [N_CORNER-1:0] CORNER_FAR_X = 4'b0110;
	localparam logic [N_CORNER-1:0] CORNER_FAR_Y = 4'b1100;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord;
		logic                      sat;
	} map_t;

	// Drop 16 fraction bits toward zero, then clamp to the coordinate range.
	function automatic map_t round_sat(input logic signed [SUM_W-1:0] s);
		map_t r;
		logic signed [QUO_W-1:0] q;
		q = $signed(s[SUM_W-1:16]);
		if (s[SUM_W-1] && (s[15:0] != 16'h0))
			q = q + QUO_W'(1);
		if ((q[QUO_W-1:COORD_W-1] == '0) || (q[QUO_W-1:COORD_W-1] == '1)) begin
			r.coord = q[COORD_W-1:0];
			r.sat   = 1'b0;
		end else begin
			r.coord = q[QUO_W-1] ? COORD_MIN : COORD_MAX;
			r.sat   = 1'b1;
		end
		return r;
	endfunction

endpackage

/* rtl/affine_rect_bounds_unit.sv */
// ----------------------------------------------------------------------------
// affine_rect_bounds_unit
// Maps the four corners of a rectangle through a 2D affine matrix and
// returns the axis-aligned bounding box of the result.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: rect_x, rect_y, rect_w, rect_h
//  m_      | out | m_tvalid/m_tready  | m_tdata: box_x, box_y, box_w, box_h;
//          |     |                    | m_tuser: clipped
//  cfg_    | in  | cfg_we             | cfg_index, cfg_data
//
//  One rectangle per cycle while the output is not stalled, through five
//  register stages (input, products, sums, round/clamp, min/max).
//  Reset loads the identity matrix with zero offset.
//  Each stage holds only while the stage after it is full and stalled, so
//  bubbles close up and new input is taken while a result waits.
// ----------------------------------------------------------------------------
module affine_rect_bounds_unit
	import arb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [31:0] rect_x, [63:32] rect_y, [94:64] rect_w, [125:95] rect_h, rest zero
	input  logic [127:0]         s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [31:0] box_x, [63:32] box_y, [95:64] box_w, [127:96] box_h
	output logic [127:0]         m_tdata,
	// [0] clipped
	output logic                 m_tuser,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	logic signed [COEF_W-1:0]  coef_a_q, coef_b_q, coef_c_q, coef_d_q;
	logic signed [COORD_W-1:0] offset_x_q, offset_y_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic load_s1, load_s2, load_s3, load_s4, load_s5;

	logic signed [EXT_W-1:0]  x0_s1, y0_s1, x1_s1, y1_s1;
	logic signed [PROD_W-1:0] pa_s2 [2];
	logic signed [PROD_W-1:0] pb_s2 [2];
	logic signed [PROD_W-1:0] pc_s2 [2];
	logic signed [PROD_W-1:0] pd_s2 [2];
	logic signed [SUM_W-1:0]  sumx_s3 [N_CORNER];
	logic signed [SUM_W-1:0]  sumy_s3 [N_CORNER];
	logic signed [COORD_W-1:0] mx_s4 [N_CORNER];
	logic signed [COORD_W-1:0] my_s4 [N_CORNER];
	logic                      sat_s4;
	logic signed [COORD_W-1:0] box_x_s5, box_y_s5;
	logic [COORD_W-1:0]        box_w_s5, box_h_s5;
	logic                      clipped_s5;

	logic signed [COORD_W-1:0] rect_x, rect_y;
	logic [SIZE_W-1:0]         rect_w, rect_h;
	logic signed [SUM_W-1:0]   offx_ext, offy_ext;
	map_t                      mapx [N_CORNER];
	map_t                      mapy [N_CORNER];
	logic                      sat_any;
	logic signed [COORD_W-1:0] minx_a, minx_b, maxx_a, maxx_b;
	logic signed [COORD_W-1:0] miny_a, miny_b, maxy_a, maxy_b;
	logic signed [COORD_W-1:0] minx, maxx, miny, maxy;

	// ---- configuration -----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q   <= COEF_ONE;
			coef_b_q   <= '0;
			coef_c_q   <= '0;
			coef_d_q   <= COEF_ONE;
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEF_A:   coef_a_q   <= cfg_data[COEF_W-1:0];
				REG_COEF_B:   coef_b_q   <= cfg_data[COEF_W-1:0];
				REG_COEF_C:   coef_c_q   <= cfg_data[COEF_W-1:0];
				REG_COEF_D:   coef_d_q   <= cfg_data[COEF_W-1:0];
				REG_OFFSET_X: offset_x_q <= cfg_data[COORD_W-1:0];
				REG_OFFSET_Y: offset_y_q <= cfg_data[COORD_W-1:0];
				default: ;    // drop writes beyond the register list
			endcase
		end
	end

	// ---- stage flow control ------------------------------------------------
	assign load_s5  = !valid_s5 || m_tready;
	assign load_s4  = !valid_s4 || load_s5;
	assign load_s3  = !valid_s3 || load_s4;
	assign load_s2  = !valid_s2 || load_s3;
	assign load_s1  = !valid_s1 || load_s2;
	assign s_tready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= s_tvalid;
			if (load_s2) valid_s2 <= valid_s1;
			if (load_s3) valid_s3 <= valid_s2;
			if (load_s4) valid_s4 <= valid_s3;
			if (load_s5) valid_s5 <= valid_s4;
		end
	end

	// ---- stage 1: input register, far corner -------------------------------
	assign rect_x = s_tdata[31:0];
	assign rect_y = s_tdata[63:32];
	assign rect_w = s_tdata[94:64];
	assign rect_h = s_tdata[125:95];

	always_ff @(posedge clk) begin
		if (load_s1 && s_tvalid) begin
			x0_s1 <= {rect_x[COORD_W-1], rect_x};
			y0_s1 <= {rect_y[COORD_W-1], rect_y};
			x1_s1 <= $signed({rect_x[COORD_W-1], rect_x}) + $signed({2'b00, rect_w});
			y1_s1 <= $signed({rect_y[COORD_W-1], rect_y}) + $signed({2'b00, rect_h});
		end
	end

	// ---- stage 2: products -------------------------------------------------
	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			pa_s2[0] <= coef_a_q * x0_s1;
			pa_s2[1] <= coef_a_q * x1_s1;
			pb_s2[0] <= coef_b_q * x0_s1;
			pb_s2[1] <= coef_b_q * x1_s1;
			pc_s2[0] <= coef_c_q * y0_s1;
			pc_s2[1] <= coef_c_q * y1_s1;
			pd_s2[0] <= coef_d_q * y0_s1;
			pd_s2[1] <= coef_d_q * y1_s1;
		end
	end

	// ---- stage 3: exact sums per corner ------------------------------------
	assign offx_ext = $signed({{(SUM_W-COORD_W-16){offset_x_q[COORD_W-1]}}, offset_x_q, 16'h0});
	assign offy_ext = $signed({{(SUM_W-COORD_W-16){offset_y_q[COORD_W-1]}}, offset_y_q, 16'h0});

	always_ff @(posedge clk) begin
		if (load_s3 && valid_s2) begin
			for (int i = 0; i < N_CORNER; i++) begin
				sumx_s3[i] <= $signed({{2{pa_s2[CORNER_FAR_X[i]][PROD_W-1]}},
				                       pa_s2[CORNER_FAR_X[i]]})
				            + $signed({{2{pc_s2[CORNER_FAR_Y[i]][PROD_W-1]}},
				                       pc_s2[CORNER_FAR_Y[i]]})
				            + offx_ext;
				sumy_s3[i] <= $signed({{2{pb_s2[CORNER_FAR_X[i]][PROD_W-1]}},
				                       pb_s2[CORNER_FAR_X[i]]})
				            + $signed({{2{pd_s2[CORNER_FAR_Y[i]][PROD_W-1]}},
				                       pd_s2[CORNER_FAR_Y[i]]})
				            + offy_ext;
			end
		end
	end

	// ---- stage 4: round toward zero and clamp ------------------------------
	always_comb begin
		sat_any = 1'b0;
		for (int i = 0; i < N_CORNER; i++) begin
			mapx[i] = round_sat(sumx_s3[i]);
			mapy[i] = round_sat(sumy_s3[i]);
			sat_any = sat_any | mapx[i].sat | mapy[i].sat;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s4 && valid_s3) begin
			for (int i = 0; i < N_CORNER; i++) begin
				mx_s4[i] <= mapx[i].coord;
				my_s4[i] <= mapy[i].coord;
			end
			sat_s4 <= sat_any;
		end
	end

	// ---- stage 5: bounding box ---------------------------------------------
	always_comb begin
		minx_a = (mx_s4[0] < mx_s4[1]) ? mx_s4[0] : mx_s4[1];
		minx_b = (mx_s4[2] < mx_s4[3]) ? mx_s4[2] : mx_s4[3];
		maxx_a = (mx_s4[0] > mx_s4[1]) ? mx_s4[0] : mx_s4[1];
		maxx_b = (mx_s4[2] > mx_s4[3]) ? mx_s4[2] : mx_s4[3];
		miny_a = (my_s4[0] < my_s4[1]) ? my_s4[0] : my_s4[1];
		miny_b = (my_s4[2] < my_s4[3]) ? my_s4[2] : my_s4[3];
		maxy_a = (my_s4[0] > my_s4[1]) ? my_s4[0] : my_s4[1];
		maxy_b = (my_s4[2] > my_s4[3]) ? my_s4[2] : my_s4[3];
		minx   = (minx_a < minx_b) ? minx_a : minx_b;
		maxx   = (maxx_a > maxx_b) ? maxx_a : maxx_b;
		miny   = (miny_a < miny_b) ? miny_a : miny_b;
		maxy   = (maxy_a > maxy_b) ? maxy_a : maxy_b;
	end

	always_ff @(posedge clk) begin
		if (load_s5 && valid_s4) begin
			box_x_s5   <= minx;
			box_y_s5   <= miny;
			// clamped corners keep the span within 32 unsigned bits
			box_w_s5   <= maxx - minx;
			box_h_s5   <= maxy - miny;
			clipped_s5 <= sat_s4;
		end
	end

	assign m_tvalid = valid_s5;
	assign m_tdata  = {box_h_s5, box_w_s5, box_y_s5, box_x_s5};
	assign m_tuser  = clipped_s5;

`ifndef SYNTHESIS
	logic rail_hit;

	always_comb begin
		rail_hit = 1'b0;
		for (int i = 0; i < N_CORNER; i++) begin
			rail_hit = rail_hit | (mx_s4[i] == COORD_MAX) | (mx_s4[i] == COORD_MIN)
			                    | (my_s4[i] == COORD_MAX) | (my_s4[i] == COORD_MIN);
		end
	end

	// a saturated corner must sit on a rail of the coordinate range
	a_sat_on_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && sat_s4) |-> rail_hit)
		else $error("clip flag set with no corner on a rail");

	// the box never reaches past the top of the coordinate range
	a_box_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (($signed({{2{box_x_s5[COORD_W-1]}}, box_x_s5})
		             + $signed({2'b00, box_w_s5})) <= 34'sh07FFFFFFF))
		else $error("box_x + box_w beyond coordinate range");

	// an empty input stage always takes a transfer
	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input refused while first stage empty");
`endif

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for affine_rect_bounds_unit. A directed stimulus table
// covers the reset matrix, coordinate extremes, saturation, rounding toward
// zero, rotation, extreme matrices and ignored register indexes. Random phases
// follow, each under a new matrix. Every transfer out is checked field by
// field against a listed box or a bounding-box predictor on a local matrix copy.
// ----------------------------------------------------------------------------
module testbench;
	import arb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
	localparam longint LIM_HI = longint'(COORD_MAX);
	localparam longint LIM_LO = longint'(COORD_MIN);
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 13;
	localparam int PHASE_RECTS  = 100;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [SIZE_W-1:0]         w;
		logic [SIZE_W-1:0]         h;
	} rect_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [COORD_W-1:0]        w;
		logic [COORD_W-1:0]        h;
		logic                      clipped;
	} box_t;

	typedef struct packed {
		logic signed [COEF_W-1:0]  a;
		logic signed [COEF_W-1:0]  b;
		logic signed [COEF_W-1:0]  c;
		logic signed [COEF_W-1:0]  d;
		logic signed [COORD_W-1:0] tx;
		logic signed [COORD_W-1:0] ty;
	} matrix_t;

	typedef enum logic {ROW_RECT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DAT_W-1:0]   data;
		rect_t                  rect;
		bit                     typed;
		box_t                   box;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [127:0]         s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [127:0]         m_tdata;
	logic                 m_tuser;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	matrix_t   mtx;
	box_t      bounds_q[$];
	plan_row_t plan[$];
	box_t      got_box;
	box_t      want_box;

	int errors;
	int cycles;
	int rects_sent;
	int boxes_checked;
	int clipped_seen;
	int reg_writes;
	int idle_pct;
	int stall_pct;
	int stall_left;
	bit quiet;

	affine_rect_bounds_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d boxes still pending", $time, bounds_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic longint map_axis(longint p, longint u, longint q, longint v,
			longint t, inout bit sat);
		longint s;
		longint quo;
		s   = p * u + q * v + t * 65536;
		quo = s / 65536;   // truncates toward zero
		if (quo > LIM_HI) begin
			sat = 1'b1;
			return LIM_HI;
		end
		if (quo < LIM_LO) begin
			sat = 1'b1;
			return LIM_LO;
		end
		return quo;
	endfunction

	function automatic box_t predict_bounds(rect_t r);
		longint a, b, c, d, tx, ty, x0, y0, x1, y1, mx, my;
		longint lo_x, hi_x, lo_y, hi_y;
		longint cx[4];
		longint cy[4];
		bit     sat;
		box_t   res;
		a  = mtx.a;
		b  = mtx.b;
		c  = mtx.c;
		d  = mtx.d;
		tx = mtx.tx;
		ty = mtx.ty;
		x0 = r.x;
		y0 = r.y;
		// far edges stay exact at full width, only mapped values clamp
		x1 = x0 + longint'(r.w);
		y1 = y0 + longint'(r.h);
		cx = '{x0, x1, x1, x0};
		cy = '{y0, y0, y1, y1};
		sat = 1'b0;
		lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
		for (int i = 0; i < 4; i++) begin
			mx = map_axis(a, cx[i], c, cy[i], tx, sat);
			my = map_axis(b, cx[i], d, cy[i], ty, sat);
			if (i == 0 || mx < lo_x) lo_x = mx;
			if (i == 0 || mx > hi_x) hi_x = mx;
			if (i == 0 || my < lo_y) lo_y = my;
			if (i == 0 || my > hi_y) hi_y = my;
		end
		res.x       = 32'(lo_x);
		res.y       = 32'(lo_y);
		res.w       = 32'(hi_x - lo_x);
		res.h       = 32'(hi_y - lo_y);
		res.clipped = sat;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Result check
	// ------------------------------------------------------------------
	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_box.x       = m_tdata[31:0];
			got_box.y       = m_tdata[63:32];
			got_box.w       = m_tdata[95:64];
			got_box.h       = m_tdata[127:96];
			got_box.clipped = m_tuser;
			if (bounds_q.size() == 0) begin
				$display("%0t: unexpected transfer out, expected none, actual %h",
					$time, got_box);
				errors++;
			end else begin
				want_box = bounds_q.pop_front();
				report_field("box_x", want_box.x, got_box.x);
				report_field("box_y", want_box.y, got_box.y);
				report_field("box_w", want_box.w, got_box.w);
				report_field("box_h", want_box.h, got_box.h);
				report_field("clipped", 32'(want_box.clipped), 32'(got_box.clipped));
				boxes_checked++;
				if (got_box.clipped === 1'b1)
					clipped_seen++;
			end
		end
	end

	// Receiver: random stall bursts, none in quiet mode.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready = 1'b0;
			stall_left--;
		end else if (!quiet && $urandom_range(99) < stall_pct) begin
			stall_left = $urandom_range(1, 11) - 1;
			m_tready   = 1'b0;
		end else begin
			m_tready = 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Sender and register writes
	// ------------------------------------------------------------------
	task automatic send_rect(input rect_t r, input bit typed, input box_t b);
		int gap;
		if (!quiet && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 11);
			@(negedge clk);
			s_tvalid = 1'b0;
			s_tdata  = {$urandom, $urandom, $urandom, $urandom};
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = {2'b00, r.h, r.w, r.y, r.x};
		do @(posedge clk); while (!s_tready);
		bounds_q.push_back(typed ? b : predict_bounds(r));
		rects_sent++;
	endtask

	// Hold the input off and let the pipeline empty.
	task automatic drain;
		@(negedge clk);
		s_tvalid = 1'b0;
		while (bounds_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we    = 1'b0;
		cfg_index = CFG_IDX_W'($urandom);
		cfg_data  = $urandom;
		case (idx)
			REG_COEF_A:   mtx.a  = data[COEF_W-1:0];
			REG_COEF_B:   mtx.b  = data[COEF_W-1:0];
			REG_COEF_C:   mtx.c  = data[COEF_W-1:0];
			REG_COEF_D:   mtx.d  = data[COEF_W-1:0];
			REG_OFFSET_X: mtx.tx = data;
			REG_OFFSET_Y: mtx.ty = data;
			default: ;
		endcase
		reg_writes++;
	endtask

	// ------------------------------------------------------------------
	// Stimulus values
	// ------------------------------------------------------------------
	function automatic rect_t mk_rect(logic [31:0] x, logic [31:0] y,
			logic [30:0] w, logic [30:0] h);
		rect_t r;
		r.x = x; r.y = y; r.w = w; r.h = h;
		return r;
	endfunction

	function automatic box_t mk_box(logic [31:0] x, logic [31:0] y,
			logic [31:0] w, logic [31:0] h, logic clipped);
		box_t b;
		b.x = x; b.y = y; b.w = w; b.h = h; b.clipped = clipped;
		return b;
	endfunction

	function automatic plan_row_t rect_row(rect_t r);
		return '{ROW_RECT, '0, '0, r, 1'b0, '0};
	endfunction

	function automatic plan_row_t typed_row(rect_t r, box_t b);
		return '{ROW_RECT, '0, '0, r, 1'b1, b};
	endfunction

	function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		return '{ROW_CFG, idx, data, '0, 1'b0, '0};
	endfunction

	// Upper byte is junk, the block must drop it.
	function automatic logic [31:0] rand_coef();
		logic [23:0] v;
		case ($urandom_range(7))
			0: v = 24'($urandom);
			1: v = 24'h7FFFFF;
			2: v = 24'h800000;
			3: v = 24'h000000;
			4: v = $urandom_range(1) ? 24'h010000 : 24'hFF0000;
			default: v = 24'($urandom_range(0, 1 << 19) - (1 << 18));
		endcase
		return {8'($urandom), v};
	endfunction

	function automatic logic [31:0] rand_offset();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			default: return 32'($urandom_range(0, 1 << 29) - (1 << 28));
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(7))
			0, 1: return $urandom;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			default: return 32'($urandom_range(0, 1 << 25) - (1 << 24));
		endcase
	endfunction

	function automatic logic [30:0] rand_size();
		case ($urandom_range(7))
			0, 1: return 31'($urandom);
			2: return 31'h7FFF_FFFF;
			3: return '0;
			default: return 31'($urandom_range(0, 1 << 22));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		errors     = 0;
		cycles     = 0;
		rects_sent = 0;
		reg_writes = 0;
		boxes_checked = 0;
		clipped_seen  = 0;
		stall_left = 0;
		idle_pct   = 25;
		stall_pct  = 25;
		quiet      = 1'b0;
		mtx.a  = COEF_ONE;
		mtx.b  = '0;
		mtx.c  = '0;
		mtx.d  = COEF_ONE;
		mtx.tx = '0;
		mtx.ty = '0;

		// reset matrix: identity, zero offset
		plan.push_back(typed_row(mk_rect(0, 0, 0, 0), mk_box(0, 0, 0, 0, 0)));
		plan.push_back(typed_row(
			mk_rect(32'h0001_0000, 32'hFFFE_0000, 31'h0003_0000, 31'h0004_0000),
			mk_box(32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 32'h0004_0000, 0)));
		// far corner past the top clamps
		plan.push_back(typed_row(
			mk_rect(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF),
			mk_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1)));
		plan.push_back(typed_row(
			mk_rect(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF),
			mk_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0)));
		plan.push_back(typed_row(mk_rect(32'h8000_0000, 32'h7FFF_FFFF, 0, 0),
			mk_box(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0)));
		// writes past the last register are dropped
		plan.push_back(cfg_row(REG_UNUSED_LO, 32'hFFFF_FFFF));
		plan.push_back(cfg_row(REG_UNUSED_HI, 32'h1234_5678));
		plan.push_back(typed_row(mk_rect(5, 7, 9, 11), mk_box(5, 7, 9, 11, 0)));
		plan.push_back(cfg_row(REG_OFFSET_X, 32'h7FFF_FFFF));
		plan.push_back(cfg_row(REG_OFFSET_Y, 32'h8000_0000));
		plan.push_back(typed_row(mk_rect(0, 0, 0, 0),
			mk_box(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0)));
		plan.push_back(rect_row(mk_rect(1, 32'hFFFF_FFFF, 1, 1)));
		// half scale: odd raw values round toward zero on both signs
		plan.push_back(cfg_row(REG_OFFSET_X, 0));
		plan.push_back(cfg_row(REG_OFFSET_Y, 0));
		plan.push_back(cfg_row(REG_COEF_A, 32'hA500_8000));
		plan.push_back(rect_row(mk_rect(1, 0, 2, 0)));
		plan.push_back(rect_row(mk_rect(32'hFFFF_FFFD, 3, 1, 0)));
		// quarter turn
		plan.push_back(cfg_row(REG_COEF_A, 0));
		plan.push_back(cfg_row(REG_COEF_B, 32'h0001_0000));
		plan.push_back(cfg_row(REG_COEF_C, 32'h00FF_0000));
		plan.push_back(cfg_row(REG_COEF_D, 0));
		plan.push_back(rect_row(
			mk_rect(32'h0001_0000, 32'h0002_0000, 31'h0003_0000, 31'h0005_0000)));
		plan.push_back(rect_row(
			mk_rect(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF)));
		// largest matrix
		plan.push_back(cfg_row(REG_COEF_A, 32'h007F_FFFF));
		plan.push_back(cfg_row(REG_COEF_B, 32'hFF7F_FFFF));
		plan.push_back(cfg_row(REG_COEF_C, 32'h007F_FFFF));
		plan.push_back(cfg_row(REG_COEF_D, 32'h007F_FFFF));
		plan.push_back(cfg_row(REG_OFFSET_X, 32'h7FFF_FFFF));
		plan.push_back(cfg_row(REG_OFFSET_Y, 32'h7FFF_FFFF));
		plan.push_back(rect_row(
			mk_rect(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF)));
		plan.push_back(rect_row(mk_rect(0, 0, 0, 0)));
		plan.push_back(rect_row(mk_rect(32'h8000_0000, 0, 0, 0)));
		// most negative matrix
		plan.push_back(cfg_row(REG_COEF_A, 32'h0080_0000));
		plan.push_back(cfg_row(REG_COEF_B, 32'h0080_0000));
		plan.push_back(cfg_row(REG_COEF_C, 32'h0080_0000));
		plan.push_back(cfg_row(REG_COEF_D, 32'h0080_0000));
		plan.push_back(cfg_row(REG_OFFSET_X, 32'h8000_0000));
		plan.push_back(cfg_row(REG_OFFSET_Y, 32'h8000_0000));
		plan.push_back(rect_row(
			mk_rect(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF)));
		plan.push_back(rect_row(
			mk_rect(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF)));
		plan.push_back(rect_row(mk_rect(1, 1, 1, 1)));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_rect(plan[i].rect, plan[i].typed, plan[i].box);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			write_reg(REG_COEF_A, rand_coef());
			write_reg(REG_COEF_B, rand_coef());
			write_reg(REG_COEF_C, rand_coef());
			write_reg(REG_COEF_D, rand_coef());
			write_reg(REG_OFFSET_X, rand_offset());
			write_reg(REG_OFFSET_Y, rand_offset());
			if ($urandom_range(2) == 0)
				write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI, $urandom);
			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 20; stall_pct = 20; end
				2: begin idle_pct = 50; stall_pct = 10; end
				default: begin idle_pct = 10; stall_pct = 50; end
			endcase
			quiet = (phase == PHASES - 1);
			repeat (PHASE_RECTS)
				send_rect(mk_rect(rand_coord(), rand_coord(), rand_size(), rand_size()),
					1'b0, '0);
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Sent %0d rectangles, checked %0d boxes (%0d clipped) across %0d register writes.",
			rects_sent, boxes_checked, clipped_seen, reg_writes);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/arb_pkg.sv
rtl/affine_rect_bounds_unit.sv
verif/testbench.sv
